@@ rtl/battery_monitor_fault_classifier_top_defines.svh @@
// Assertion macros for the battery monitor fault classifier checker.
// Included by files that assert; depends on nothing else.
`ifndef BATTERY_MONITOR_FAULT_CLASSIFIER_TOP_DEFINES_SVH
`define BATTERY_MONITOR_FAULT_CLASSIFIER_TOP_DEFINES_SVH

// Same-cycle implication or plain property, disabled during reset.
`define BMFC_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent this cycle, consequent on the next cycle.
`define BMFC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/bmfc_pkg.sv @@
// Shared types, codes and constants of the battery monitor fault classifier.
// No dependencies.
`default_nettype none

package bmfc_pkg;

  localparam int unsigned CMD_W       = 3;
  localparam int unsigned RAW_W       = 16;
  localparam int unsigned CAP_W       = 32;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned NUM_KINDS   = 4;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned TDATA_IN_W  = 104;
  localparam int unsigned TDATA_OUT_W = 104;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 3'd0,
    CMD_MINMAX   = 3'd1,
    CMD_READY    = 3'd2,
    CMD_KILL     = 3'd3,
    CMD_MEAS     = 3'd4,
    CMD_CAPACITY = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    FAULT_NONE      = 3'd0,
    FAULT_KILLED    = 3'd1,
    FAULT_UNDERVOLT = 3'd2,
    FAULT_OVERVOLT  = 3'd3,
    FAULT_OVERTEMP  = 3'd4,
    FAULT_TIMEOUT   = 3'd5
  } fault_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UNDERVOLT = 2'd0,
    REG_OVERVOLT  = 2'd1,
    REG_OVERTEMP  = 2'd2,
    REG_TIMEOUT   = 2'd3
  } cfg_idx_e;

  // Slots of the arrival-time table.
  localparam logic [1:0] KIND_MINMAX = 2'd0;
  localparam logic [1:0] KIND_READY  = 2'd1;
  localparam logic [1:0] KIND_KILL   = 2'd2;
  localparam logic [1:0] KIND_MEAS   = 2'd3;

  localparam logic [CFG_DATA_W-1:0] UNDERVOLT_RST = 16'h0000;
  localparam logic [CFG_DATA_W-1:0] OVERVOLT_RST  = 16'hFFFF;
  localparam logic [CFG_DATA_W-1:0] OVERTEMP_RST  = 16'h7FFF;
  localparam logic [CFG_DATA_W-1:0] TIMEOUT_RST   = 16'd1000;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [RAW_W-1:0] cell_vmax;
    logic [RAW_W-1:0] cell_tmax;
    logic             ready;
    logic             killed;
    logic [RAW_W-1:0] pack_volt;
    logic [RAW_W-1:0] pack_current;
    logic [CAP_W-1:0] capacity;
  } item_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] undervolt;
    logic [CFG_DATA_W-1:0] overvolt;
    logic [CFG_DATA_W-1:0] overtemp;
    logic [CFG_DATA_W-1:0] timeout;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]                now_ms;
    logic [NUM_KINDS-1:0][TIME_W-1:0] last_seen;
    logic [NUM_KINDS-1:0]             seen;
    logic [RAW_W-1:0]                 cell_voltage;
    logic [RAW_W-1:0]                 cell_temp;
    logic [RAW_W-1:0]                 pack_volt;
    logic [RAW_W-1:0]                 pack_current;
    logic [CAP_W-1:0]                 capacity;
    logic                             ready;
    logic                             killed;
  } status_t;

  typedef struct packed {
    fault_e           fault;
    logic             alive;
    logic             charge_ready;
    logic             battery_killed;
    logic [RAW_W-1:0] cell_voltage;
    logic [RAW_W-1:0] cell_temp;
    logic [RAW_W-1:0] pack_volt;
    logic [RAW_W-1:0] pack_current;
    logic [CAP_W-1:0] capacity;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/battery_monitor_fault_classifier_top.sv @@
// Top level of the battery monitor fault classifier: stream ports, input
// and result registers. Depends on bmfc_pkg, bmfc_state and bmfc_classify.
//
// Usage:
//  - Slave stream carries one transaction per item: tuser is the command
//    (tick or one of five message kinds), tdata the message payload.
//  - Master stream returns exactly one result transaction per input item,
//    in order: fault code, comms-alive flag and all latched raw values.
//  - Config port: cfg_we_i writes cfg_wdata_i to register cfg_addr_i at a
//    rising edge; write only while no transaction is in flight.
//  - Path: each accepted item enters the input register, then moves to the
//    result register once that is free or draining.
//  - Throughput: one item per cycle unless the output stalls; the single
//    state-update and compare path between the two registers sets this figure.
//  - Stall: when m_axis_tready_i is low the result holds, one more item
//    waits in the input register, and s_axis_tready_o drops only when both
//    are full.
//  - Reset: both registers empty, latched values and time zero, seen marks
//    clear, limits at their defaults.
`default_nettype none

module battery_monitor_fault_classifier_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [bmfc_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input  wire logic [bmfc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // tdata, low bit up: cell_vmax_raw[15:0], cell_tmax_raw[31:16],
  // ready_flag[32], killed_flag[33], pack_volt_raw[49:34],
  // pack_current_raw[65:50], capacity_wh[97:66], zero pad[103:98]
  input  wire logic [bmfc_pkg::TDATA_IN_W-1:0]     s_axis_tdata_i,
  // tuser: cmd[2:0]
  input  wire logic [bmfc_pkg::CMD_W-1:0]          s_axis_tuser_i,
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // tdata, low bit up: fault_code[2:0], comms_alive[3], charge_ready[4],
  // battery_killed[5], cell_voltage_out[21:6], cell_temp_out[37:22],
  // pack_volt_out[53:38], pack_current_out[69:54],
  // capacity_out[101:70], zero pad[103:102]
  output logic [bmfc_pkg::TDATA_OUT_W-1:0]         m_axis_tdata_o
);

  bmfc_pkg::item_t   in_item_d, in_item_q;
  logic              in_valid_q;
  bmfc_pkg::result_t res_d, res_q;
  logic              out_valid_q;
  logic              adv;
  logic              in_take;
  bmfc_pkg::cfg_t    cfg;
  bmfc_pkg::status_t status_nxt;

  // Move the held item forward whenever the result slot is free or draining.
  assign adv             = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || adv;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  assign in_item_d.cmd          = s_axis_tuser_i;
  assign in_item_d.cell_vmax    = s_axis_tdata_i[15:0];
  assign in_item_d.cell_tmax    = s_axis_tdata_i[31:16];
  assign in_item_d.ready        = s_axis_tdata_i[32];
  assign in_item_d.killed       = s_axis_tdata_i[33];
  assign in_item_d.pack_volt    = s_axis_tdata_i[49:34];
  assign in_item_d.pack_current = s_axis_tdata_i[65:50];
  assign in_item_d.capacity     = s_axis_tdata_i[97:66];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_d;
    end
  end

  bmfc_state u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .adv_i       (adv),
    .item_i      (in_item_q),
    .cfg_o       (cfg),
    .status_o    (status_nxt)
  );

  bmfc_classify u_classify (
    .cfg_i    (cfg),
    .status_i (status_nxt),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00,
                            res_q.capacity,
                            res_q.pack_current,
                            res_q.pack_volt,
                            res_q.cell_temp,
                            res_q.cell_voltage,
                            res_q.battery_killed,
                            res_q.charge_ready,
                            res_q.alive,
                            res_q.fault};

endmodule

`default_nettype wire

@@ rtl/bmfc_state.sv @@
// Configuration registers and latched battery state with next-state logic.
// Depends on bmfc_pkg.
`default_nettype none

module bmfc_state (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [bmfc_pkg::CFG_IDX_W-1:0]   cfg_addr_i,
  input  wire logic [bmfc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                             adv_i,
  input  wire bmfc_pkg::item_t                  item_i,
  output bmfc_pkg::cfg_t                        cfg_o,
  output bmfc_pkg::status_t                     status_o
);

  bmfc_pkg::cfg_t    cfg_q;
  bmfc_pkg::status_t st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.undervolt <= bmfc_pkg::UNDERVOLT_RST;
      cfg_q.overvolt  <= bmfc_pkg::OVERVOLT_RST;
      cfg_q.overtemp  <= bmfc_pkg::OVERTEMP_RST;
      cfg_q.timeout   <= bmfc_pkg::TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (bmfc_pkg::cfg_idx_e'(cfg_addr_i))
        bmfc_pkg::REG_UNDERVOLT: cfg_q.undervolt <= cfg_wdata_i;
        bmfc_pkg::REG_OVERVOLT:  cfg_q.overvolt  <= cfg_wdata_i;
        bmfc_pkg::REG_OVERTEMP:  cfg_q.overtemp  <= cfg_wdata_i;
        bmfc_pkg::REG_TIMEOUT:   cfg_q.timeout   <= cfg_wdata_i;
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  // Messages other than capacity stamp the current time; ticks alone advance it.
  always_comb begin
    st_d = st_q;
    case (bmfc_pkg::cmd_e'(item_i.cmd))
      bmfc_pkg::CMD_TICK: begin
        st_d.now_ms = st_q.now_ms + 32'd1;
      end
      bmfc_pkg::CMD_MINMAX: begin
        st_d.cell_voltage                     = item_i.cell_vmax;
        st_d.cell_temp                        = item_i.cell_tmax;
        st_d.last_seen[bmfc_pkg::KIND_MINMAX] = st_q.now_ms;
        st_d.seen[bmfc_pkg::KIND_MINMAX]      = 1'b1;
      end
      bmfc_pkg::CMD_READY: begin
        st_d.ready                           = item_i.ready;
        st_d.last_seen[bmfc_pkg::KIND_READY] = st_q.now_ms;
        st_d.seen[bmfc_pkg::KIND_READY]      = 1'b1;
      end
      bmfc_pkg::CMD_KILL: begin
        st_d.killed                         = item_i.killed;
        st_d.last_seen[bmfc_pkg::KIND_KILL] = st_q.now_ms;
        st_d.seen[bmfc_pkg::KIND_KILL]      = 1'b1;
      end
      bmfc_pkg::CMD_MEAS: begin
        st_d.pack_volt                      = item_i.pack_volt;
        st_d.pack_current                   = item_i.pack_current;
        st_d.last_seen[bmfc_pkg::KIND_MEAS] = st_q.now_ms;
        st_d.seen[bmfc_pkg::KIND_MEAS]      = 1'b1;
      end
      bmfc_pkg::CMD_CAPACITY: begin
        st_d.capacity = item_i.capacity;
      end
      default: st_d = st_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (adv_i) begin
      st_q <= st_d;
    end
  end

  assign cfg_o    = cfg_q;
  assign status_o = st_d;

endmodule

`default_nettype wire

@@ rtl/bmfc_classify.sv @@
// Freshness check and priority fault classification on the updated state.
// Depends on bmfc_pkg.
`default_nettype none

module bmfc_classify (
  input  wire bmfc_pkg::cfg_t     cfg_i,
  input  wire bmfc_pkg::status_t  status_i,
  output bmfc_pkg::result_t       result_o
);

  logic [bmfc_pkg::NUM_KINDS-1:0] fresh;
  logic [bmfc_pkg::TIME_W-1:0]    limit;
  logic                           alive;

  assign limit = {{(bmfc_pkg::TIME_W - bmfc_pkg::CFG_DATA_W){1'b0}}, cfg_i.timeout};

  // Age wraps at 32 bits; a zero limit leaves nothing fresh.
  always_comb begin
    for (int k = 0; k < bmfc_pkg::NUM_KINDS; k++) begin
      fresh[k] = (status_i.now_ms - status_i.last_seen[k]) < limit;
    end
  end

  assign alive = (&status_i.seen) && (&fresh);

  always_comb begin
    if (status_i.killed) begin
      result_o.fault = bmfc_pkg::FAULT_KILLED;
    end else if (status_i.pack_volt <= cfg_i.undervolt) begin
      result_o.fault = bmfc_pkg::FAULT_UNDERVOLT;
    end else if (status_i.pack_volt >= cfg_i.overvolt) begin
      result_o.fault = bmfc_pkg::FAULT_OVERVOLT;
    end else if ($signed(status_i.cell_temp) >= $signed(cfg_i.overtemp)) begin
      result_o.fault = bmfc_pkg::FAULT_OVERTEMP;
    end else if (!alive) begin
      result_o.fault = bmfc_pkg::FAULT_TIMEOUT;
    end else begin
      result_o.fault = bmfc_pkg::FAULT_NONE;
    end
    result_o.alive          = alive;
    result_o.charge_ready   = status_i.ready;
    result_o.battery_killed = status_i.killed;
    result_o.cell_voltage   = status_i.cell_voltage;
    result_o.cell_temp      = status_i.cell_temp;
    result_o.pack_volt      = status_i.pack_volt;
    result_o.pack_current   = status_i.pack_current;
    result_o.capacity       = status_i.capacity;
  end

endmodule

`default_nettype wire

@@ rtl/bmfc_checker.sv @@
// Port-level checker for the battery monitor fault classifier, bound to the
// top level. Depends on bmfc_pkg and the assertion macro header.
`default_nettype none

`include "battery_monitor_fault_classifier_top_defines.svh"

module bmfc_assert_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tvalid_i,
  input wire logic                              s_axis_tready_o,
  input wire logic                              m_axis_tvalid_o,
  input wire logic                              m_axis_tready_i,
  input wire logic [bmfc_pkg::TDATA_OUT_W-1:0]  m_axis_tdata_o
);

  logic [2:0] fault;
  logic       alive;
  logic       killed;

  assign fault  = m_axis_tdata_o[2:0];
  assign alive  = m_axis_tdata_o[3];
  assign killed = m_axis_tdata_o[5];

  // A stalled result transaction holds still.
  `BMFC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled result changed")

  // Input back-pressure only while a result is stuck at the output.
  `BMFC_ASSERT(a_in_stall, clk_i, rst_ni, !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i), "input stalled without output stall")

  // Kill flag has top priority and is the only source of the killed code.
  `BMFC_ASSERT(a_kill_code, clk_i, rst_ni, m_axis_tvalid_o |-> ((fault == bmfc_pkg::FAULT_KILLED) == killed), "killed code and flag disagree")

  // No fault only when comms are alive; timeout never while alive.
  `BMFC_ASSERT(a_alive_code, clk_i, rst_ni, m_axis_tvalid_o |-> ((fault != bmfc_pkg::FAULT_NONE) || alive) && !((fault == bmfc_pkg::FAULT_TIMEOUT) && alive), "fault code and comms alive disagree")

endmodule

bind battery_monitor_fault_classifier_top bmfc_assert_checker u_checker (.*);

`default_nettype wire

@@ verif/bmfc_checker.sv @@
// Checker for the battery monitor fault classifier: watches both stream channels
// and the config port, predicts every result and compares it field by field.
// Depends on bmfc_pkg.
`default_nettype none

module bmfc_checker
  import bmfc_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                   s_axis_tvalid_i,
  input  wire logic                   s_axis_tready_i,
  input  wire logic [TDATA_IN_W-1:0]  s_axis_tdata_i,
  input  wire logic [CMD_W-1:0]       s_axis_tuser_i,
  input  wire logic                   m_axis_tvalid_i,
  input  wire logic                   m_axis_tready_i,
  input  wire logic [TDATA_OUT_W-1:0] m_axis_tdata_i,
  output int                          mismatch_count_o,
  output int                          reports_due_o
);

  // Shadow of the block's state and limits
  logic [TIME_W-1:0]     clock_ms;
  logic [TIME_W-1:0]     arrival_ms [NUM_KINDS];
  logic [NUM_KINDS-1:0]  seen_kinds;
  logic [RAW_W-1:0]      cell_mv_q;
  logic [RAW_W-1:0]      cell_temp_q;
  logic [RAW_W-1:0]      pack_mv_q;
  logic [RAW_W-1:0]      pack_ma_q;
  logic [CAP_W-1:0]      energy_q;
  logic                  ready_q;
  logic                  killed_q;
  logic [CFG_DATA_W-1:0] lim_under;
  logic [CFG_DATA_W-1:0] lim_over;
  logic [CFG_DATA_W-1:0] lim_temp;
  logic [CFG_DATA_W-1:0] stale_after;

  result_t expected_reports [$];
  int      mismatches;

  // All four timed kinds seen and younger than the stale age (wrapping age).
  function automatic logic kinds_fresh();
    logic [TIME_W-1:0] age;
    kinds_fresh = (seen_kinds == '1);
    for (int k = 0; k < NUM_KINDS; k++) begin
      age = clock_ms - arrival_ms[k];
      if (age >= {16'b0, stale_after}) kinds_fresh = 1'b0;
    end
  endfunction

  task automatic stamp(input logic [1:0] kind);
    arrival_ms[kind] = clock_ms;
    seen_kinds[kind] = 1'b1;
  endtask

  task automatic predict_report(input logic [CMD_W-1:0] cmd,
                                input logic [TDATA_IN_W-1:0] pl,
                                output result_t rep);
    case (cmd)
      CMD_TICK: clock_ms = clock_ms + 1'b1;
      CMD_MINMAX: begin
        cell_mv_q   = pl[15:0];
        cell_temp_q = pl[31:16];
        stamp(KIND_MINMAX);
      end
      CMD_READY: begin
        ready_q = pl[32];
        stamp(KIND_READY);
      end
      CMD_KILL: begin
        killed_q = pl[33];
        stamp(KIND_KILL);
      end
      CMD_MEAS: begin
        pack_mv_q = pl[49:34];
        pack_ma_q = pl[65:50];
        stamp(KIND_MEAS);
      end
      CMD_CAPACITY: energy_q = pl[97:66];
      default: ;
    endcase

    rep.alive = kinds_fresh();
    if (killed_q)                                    rep.fault = FAULT_KILLED;
    else if (pack_mv_q <= lim_under)                 rep.fault = FAULT_UNDERVOLT;
    else if (pack_mv_q >= lim_over)                  rep.fault = FAULT_OVERVOLT;
    else if ($signed(cell_temp_q) >= $signed(lim_temp)) rep.fault = FAULT_OVERTEMP;
    else if (!rep.alive)                             rep.fault = FAULT_TIMEOUT;
    else                                             rep.fault = FAULT_NONE;
    rep.charge_ready   = ready_q;
    rep.battery_killed = killed_q;
    rep.cell_voltage   = cell_mv_q;
    rep.cell_temp      = cell_temp_q;
    rep.pack_volt      = pack_mv_q;
    rep.pack_current   = pack_ma_q;
    rep.capacity       = energy_q;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  task automatic check_report(input logic [TDATA_OUT_W-1:0] bus);
    result_t want;
    if (expected_reports.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result: expected none, actual %h", $time, bus);
    end else begin
      want = expected_reports.pop_front();
      check_field("fault_code",       want.fault,          bus[2:0]);
      check_field("comms_alive",      want.alive,          bus[3]);
      check_field("charge_ready",     want.charge_ready,   bus[4]);
      check_field("battery_killed",   want.battery_killed, bus[5]);
      check_field("cell_voltage_out", want.cell_voltage,   bus[21:6]);
      check_field("cell_temp_out",    want.cell_temp,      bus[37:22]);
      check_field("pack_volt_out",    want.pack_volt,      bus[53:38]);
      check_field("pack_current_out", want.pack_current,   bus[69:54]);
      check_field("capacity_out",     want.capacity,       bus[101:70]);
      check_field("tdata pad",        '0,                  bus[103:102]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t rep;
    if (!rst_ni) begin
      clock_ms    = '0;
      for (int k = 0; k < NUM_KINDS; k++) arrival_ms[k] = '0;
      seen_kinds  = '0;
      cell_mv_q   = '0;
      cell_temp_q = '0;
      pack_mv_q   = '0;
      pack_ma_q   = '0;
      energy_q    = '0;
      ready_q     = 1'b0;
      killed_q    = 1'b0;
      lim_under   = UNDERVOLT_RST;
      lim_over    = OVERVOLT_RST;
      lim_temp    = OVERTEMP_RST;
      stale_after = TIMEOUT_RST;
      expected_reports.delete();
      mismatches  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_UNDERVOLT: lim_under   = cfg_wdata_i;
          REG_OVERVOLT:  lim_over    = cfg_wdata_i;
          REG_OVERTEMP:  lim_temp    = cfg_wdata_i;
          REG_TIMEOUT:   stale_after = cfg_wdata_i;
          default: ;
        endcase
      end
      // Result for an item never leaves on the edge that accepts it, so pop first.
      if (m_axis_tvalid_i && m_axis_tready_i) check_report(m_axis_tdata_i);
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_report(s_axis_tuser_i, s_axis_tdata_i, rep);
        expected_reports.push_back(rep);
      end
    end
    mismatch_count_o <= mismatches;
    reports_due_o    <= expected_reports.size();
  end

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Top of the fault classifier testbench: clock, reset, stimulus, back-pressure,
// watchdog and verdict. Depends on bmfc_pkg, bmfc_checker and the block's RTL.
`default_nettype none

module testbench;
  import bmfc_pkg::*;

  // Commands with no meaning to the block; they must leave state untouched.
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  // Extra quiet after draining, before any config write.
  localparam int SETTLE_CYCLES  = 4;
  // Far longer than the longest sender gap or receiver stall.
  localparam int WATCHDOG_LIMIT = 2000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_addr_i;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i;
  logic                   s_axis_tvalid_i;
  wire logic              s_axis_tready_o;
  logic [TDATA_IN_W-1:0]  s_axis_tdata_i;
  logic [CMD_W-1:0]       s_axis_tuser_i;
  wire logic              m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  wire logic [TDATA_OUT_W-1:0] m_axis_tdata_o;

  int mismatch_count;
  int reports_due;
  int quiet_cycles;

  // Limits as last programmed, used to aim random values at the thresholds.
  logic [15:0] cur_under;
  logic [15:0] cur_over;
  logic [15:0] cur_temp;

  battery_monitor_fault_classifier_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  bmfc_checker report_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .s_axis_tvalid_i  (s_axis_tvalid_i),
    .s_axis_tready_i  (s_axis_tready_o),
    .s_axis_tdata_i   (s_axis_tdata_i),
    .s_axis_tuser_i   (s_axis_tuser_i),
    .m_axis_tvalid_i  (m_axis_tvalid_o),
    .m_axis_tready_i  (m_axis_tready_i),
    .m_axis_tdata_i   (m_axis_tdata_o),
    .mismatch_count_o (mismatch_count),
    .reports_due_o    (reports_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: any cycle with a transaction on either channel restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((s_axis_tvalid_i && s_axis_tready_o) ||
                 (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver back-pressure: ready runs (some long, so there are stall-free
  // stretches) alternate with stalls, mostly short and now and then long.
  initial begin : receiver
    int run_len;
    int stall_len;
    int pick;
    m_axis_tready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      pick    = $urandom_range(0, 99);
      run_len = (pick < 30) ? $urandom_range(20, 80) : $urandom_range(1, 6);
      m_axis_tready_i <= 1'b1;
      repeat (run_len) @(posedge clk_i);
      pick = $urandom_range(0, 99);
      if (pick < 80)      stall_len = $urandom_range(1, 3);
      else if (pick < 95) stall_len = $urandom_range(4, 10);
      else                stall_len = $urandom_range(20, 40);
      m_axis_tready_i <= 1'b0;
      repeat (stall_len) @(posedge clk_i);
    end
  end

  // tdata layout, low bit up; top six bits stay zero.
  function automatic logic [TDATA_IN_W-1:0] pack_payload(
      input logic [15:0] cell_mv, input logic [15:0] cell_temp,
      input logic rdy, input logic kil, input logic [15:0] pack_mv,
      input logic [15:0] pack_ma, input logic [31:0] energy);
    pack_payload = {6'b0, energy, pack_ma, pack_mv, kil, rdy, cell_temp, cell_mv};
  endfunction

  // One below, at, or one above a threshold (wrapping at the ends).
  function automatic logic [15:0] near_limit(input logic [15:0] lim);
    case ($urandom_range(0, 2))
      0:       near_limit = lim - 16'd1;
      1:       near_limit = lim;
      default: near_limit = lim + 16'd1;
    endcase
  endfunction

  // All fields random; temperature and pack voltage often sit on a threshold,
  // and the kill flag is mostly clear so lower-priority faults get a chance.
  function automatic logic [TDATA_IN_W-1:0] random_payload();
    logic [15:0] temp;
    logic [15:0] pv;
    int          pick;
    temp = ($urandom_range(0, 1) == 0) ? near_limit(cur_temp) : 16'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 2)      pv = near_limit(cur_under);
    else if (pick < 4) pv = near_limit(cur_over);
    else               pv = 16'($urandom);
    random_payload = pack_payload(16'($urandom), temp, 1'($urandom),
                                  ($urandom_range(0, 99) < 15), pv,
                                  16'($urandom), $urandom);
  endfunction

  // Sender gap: mostly back to back, some short, a few long.
  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65)      pick_gap = 0;
    else if (pick < 93) pick_gap = $urandom_range(1, 3);
    else                pick_gap = $urandom_range(8, 40);
  endfunction

  // Offer one item and hold it until the transaction completes. tvalid only
  // drops when a gap follows, so back-to-back items see a single assignment.
  task automatic offer_item(input logic [CMD_W-1:0] cmd,
                            input logic [TDATA_IN_W-1:0] payload);
    int gap;
    gap = pick_gap();
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= payload;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every predicted result has been taken.
  // reports_due is updated by nonblocking assignment, so the first edge
  // makes sure the last accepted item is already counted.
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (reports_due != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  // Config only changes with the block idle.
  task automatic program_limits(input logic [15:0] under, input logic [15:0] over,
                                input logic [15:0] temp, input logic [15:0] stale);
    wait_drained();
    write_reg(REG_UNDERVOLT, under);
    write_reg(REG_OVERVOLT, over);
    write_reg(REG_OVERTEMP, temp);
    write_reg(REG_TIMEOUT, stale);
    cfg_we_i  <= 1'b0;
    cur_under  = under;
    cur_over   = over;
    cur_temp   = temp;
  endtask

  // Random traffic. About one pass in five is a full refresh (all four timed
  // kinds in a row) so comms can become alive and the healthy path is reached;
  // the rest is a weighted mix of ticks, single messages and spare commands.
  // Halfway through, the sender holds off until every result is back.
  task automatic run_random(input int count);
    int sent;
    int pick;
    logic [CMD_W-1:0] cmd;
    logic [TDATA_IN_W-1:0] pl;
    bit held_off;
    sent     = 0;
    held_off = 1'b0;
    while (sent < count) begin
      if (!held_off && sent >= count / 2) begin
        wait_drained();
        held_off = 1'b1;
      end
      if ($urandom_range(0, 9) < 2) begin
        offer_item(CMD_MINMAX, random_payload());
        offer_item(CMD_READY, random_payload());
        pl = random_payload();
        pl[33] = ($urandom_range(0, 9) == 0);
        offer_item(CMD_KILL, pl);
        offer_item(CMD_MEAS, random_payload());
        sent += 4;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 40)      cmd = CMD_TICK;
        else if (pick < 52) cmd = CMD_MINMAX;
        else if (pick < 62) cmd = CMD_READY;
        else if (pick < 72) cmd = CMD_KILL;
        else if (pick < 86) cmd = CMD_MEAS;
        else if (pick < 94) cmd = CMD_CAPACITY;
        else if (pick < 97) cmd = CMD_SPARE_LO;
        else                cmd = CMD_SPARE_HI;
        offer_item(cmd, random_payload());
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    logic [15:0] under;
    logic [15:0] over;
    cfg_we_i        = 1'b0;
    cfg_addr_i      = REG_UNDERVOLT;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = CMD_TICK;
    cur_under       = UNDERVOLT_RST;
    cur_over        = OVERVOLT_RST;
    cur_temp        = OVERTEMP_RST;
    rst_ni          = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset limits. Tick and the low spare command carry all-ones
    // payloads, the high spare zeros, all ignored; then each message at field extremes.
    offer_item(CMD_TICK, pack_payload('1, '1, 1'b1, 1'b1, '1, '1, '1));
    offer_item(CMD_SPARE_LO, pack_payload('1, '1, 1'b1, 1'b1, '1, '1, '1));
    offer_item(CMD_SPARE_HI, '0);
    offer_item(CMD_MINMAX, pack_payload(16'hFFFF, 16'h7FFF, 1'b1, 1'b1, '1, '1, '1));
    offer_item(CMD_MINMAX, pack_payload(16'h0000, 16'h8000, 1'b0, 1'b0, '0, '0, '0));
    offer_item(CMD_READY, pack_payload('0, '0, 1'b1, 1'b0, '0, '0, '0));
    // Kill outranks everything else.
    offer_item(CMD_KILL, pack_payload('0, '0, 1'b0, 1'b1, '0, '0, '0));
    offer_item(CMD_MEAS, pack_payload('0, '0, 1'b0, 1'b0, 16'hFFFF, 16'h8000, '0));
    offer_item(CMD_KILL, pack_payload('1, '1, 1'b1, 1'b0, '1, '1, '1));
    // Pack voltage at the reset undervolt limit (zero) counts as undervolt.
    offer_item(CMD_MEAS, pack_payload('1, '1, 1'b1, 1'b1, 16'h0000, 16'h7FFF, '1));
    offer_item(CMD_CAPACITY, pack_payload('0, '0, 1'b0, 1'b0, '0, '0, 32'hFFFF_FFFF));
    offer_item(CMD_CAPACITY, pack_payload('1, '1, 1'b1, 1'b1, '1, '1, 32'h0));
    offer_item(CMD_READY, pack_payload('1, '1, 1'b0, 1'b1, '1, '1, '1));
    // All four kinds now fresh and values in range: no fault, comms alive.
    offer_item(CMD_MEAS, pack_payload('0, '0, 1'b0, 1'b0, 16'h1234, 16'h0000, '0));
    // Max temperature at the limit trips overtemp.
    offer_item(CMD_MINMAX, pack_payload(16'hFFFF, 16'h7FFF, 1'b0, 1'b0, '0, '0, '0));
    offer_item(CMD_MINMAX, pack_payload(16'h8000, 16'hFFFF, 1'b0, 1'b0, '0, '0, '0));
    offer_item(CMD_MEAS, pack_payload('0, '0, 1'b0, 1'b0, 16'hFFFE, 16'hFFFF, '0));
    repeat (3) offer_item(CMD_TICK, '0);

    // Wide window around mid-scale, short stale age.
    program_limits(16'h1000, 16'hF000, 16'h0100, 16'd8);
    run_random(150);

    // Extremes: everything under- and overvolt, any temperature overtemp,
    // the longest stale age.
    program_limits(16'hFFFF, 16'h0000, 16'h8000, 16'hFFFF);
    run_random(100);

    // Zero stale age: comms can never be alive.
    program_limits(16'h0000, 16'hFFFF, 16'h7FFF, 16'h0000);
    run_random(100);

    // Stale after a single tick.
    program_limits(16'd100, 16'd200, 16'h0000, 16'd1);
    run_random(100);

    // Random but ordered limits with small stale ages.
    repeat (3) begin
      under = 16'($urandom_range(0, 16'h7FFF));
      over  = under + 16'($urandom_range(1, 16'h7FFF));
      program_limits(under, over, 16'($urandom), 16'($urandom_range(1, 40)));
      run_random(100);
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ battery_monitor_fault_classifier_top.f @@
+incdir+rtl
rtl/bmfc_pkg.sv
rtl/bmfc_state.sv
rtl/bmfc_classify.sv
rtl/battery_monitor_fault_classifier_top.sv
rtl/bmfc_checker.sv
verif/bmfc_checker.sv
verif/testbench.sv
